[rtl/apsp_pkg.sv]
package apsp_pkg;

    // field widths fixed by the interface
    localparam int VERT_W    = 6;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    // longest route reported in one run
    localparam int HOP_CAP = 32;

    // item codes
    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_EDGE  = 2'd1,
        MODE_SOLVE = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VCOUNT = 2'd0,
        CFG_SOURCE = 2'd1,
        CFG_TARGET = 2'd2,
        CFG_METRIC = 2'd3
    } cfg_index_t;

    localparam logic [VERT_W-1:0] VCOUNT_RST = 6'd32;
    localparam logic [VERT_W-1:0] VERTEX_RST = 6'd1;

endpackage

[rtl/apsp_ram.sv]
module apsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first, one write and two registered reads per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[rtl/apsp_relax.sv]
module apsp_relax #(
    parameter int COST_WIDTH = 24
)(
    input  logic                  metric,
    input  logic [COST_WIDTH-1:0] ik_dist,
    input  logic [COST_WIDTH-1:0] ik_time,
    input  logic [COST_WIDTH-1:0] kj_dist,
    input  logic [COST_WIDTH-1:0] kj_time,
    input  logic [COST_WIDTH-1:0] ij_dist,
    input  logic [COST_WIDTH-1:0] ij_time,
    output logic [COST_WIDTH-1:0] sum_dist,
    output logic [COST_WIDTH-1:0] sum_time,
    output logic                  better
);

    logic [COST_WIDTH:0] raw_dist;
    logic [COST_WIDTH:0] raw_time;

    // saturate at the infinity code on carry
    assign raw_dist = {1'b0, ik_dist} + {1'b0, kj_dist};
    assign raw_time = {1'b0, ik_time} + {1'b0, kj_time};
    assign sum_dist = raw_dist[COST_WIDTH] ? {COST_WIDTH{1'b1}} : raw_dist[COST_WIDTH-1:0];
    assign sum_time = raw_time[COST_WIDTH] ? {COST_WIDTH{1'b1}} : raw_time[COST_WIDTH-1:0];

    // strict compare, ties keep the stored entry
    assign better = metric ? (sum_time < ij_time) : (sum_dist < ij_dist);

endmodule

[rtl/all_pairs_shortest_path_dual_cost.sv]
// channel   direction  handshake              payload
// config    in         wr_en                  wr_index, wr_data
// item      in         start && !busy         mode, edge_from, edge_to, edge_distance, edge_time
// result    out        result_valid (1 cycle) reachable, hop_from, hop_to, total_distance,
//                                             total_time, last
//
// clear: one pass over the matrix memory
// edge load: a read-modify-write that keeps the stored next hop
// solve: relaxation, one pair per cycle within a row pass, with set-up states ST_SETUP and
//   ST_LOADIK before each row, as the row pass takes both read ports; then the route report
// reset runs the same clearing pass as a clear item; busy is high meanwhile
// results come one per cycle at most and cannot be held off by the receiver
module all_pairs_shortest_path_dual_cost
    import apsp_pkg::*;
#(
    parameter int MAX_VERTICES    = 32,
    parameter int COST_WIDTH      = 24,
    parameter int EDGE_COST_WIDTH = 16
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [CFG_IDX_W-1:0]       wr_index,
    input  logic [VERT_W-1:0]          wr_data,
    input  logic                       start,
    output logic                       busy,
    input  logic [MODE_W-1:0]          mode,
    input  logic [VERT_W-1:0]          edge_from,
    input  logic [VERT_W-1:0]          edge_to,
    input  logic [EDGE_COST_WIDTH-1:0] edge_distance,
    input  logic [EDGE_COST_WIDTH-1:0] edge_time,
    output logic                       result_valid,
    output logic                       reachable,
    output logic [VERT_W-1:0]          hop_from,
    output logic [VERT_W-1:0]          hop_to,
    output logic [COST_WIDTH-1:0]      total_distance,
    output logic [COST_WIDTH-1:0]      total_time,
    output logic                       last
);

    localparam int IW        = $clog2(MAX_VERTICES);
    localparam int NW        = $clog2(MAX_VERTICES + 1);
    localparam int AW        = 2 * IW;
    localparam int DEPTH     = 1 << AW;
    localparam int EW        = 2 * COST_WIDTH + NW;
    localparam int HOP_LIMIT = (MAX_VERTICES < HOP_CAP) ? MAX_VERTICES : HOP_CAP;
    localparam int CW        = $clog2(HOP_CAP + 1);
    localparam logic [COST_WIDTH-1:0] INF = {COST_WIDTH{1'b1}};

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_SETUP,
        ST_LOADIK,
        ST_ROW,
        ST_REP_START,
        ST_REP_COST,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_EMIT_LAST
    } state_t;

    state_t state_reg;

    // configuration
    logic [VERT_W-1:0] vcount_reg;
    logic [VERT_W-1:0] src_reg;
    logic [VERT_W-1:0] tgt_reg;
    logic              metric_reg;

    // sweep and loop counters
    logic [AW-1:0] clr_addr_reg;
    logic [IW-1:0] k_reg;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] j_reg;

    // relaxation pipeline stage
    logic                  pv_reg;
    logic [IW-1:0]         pi_reg;
    logic [IW-1:0]         pj_reg;
    logic [COST_WIDTH-1:0] ik_d_reg;
    logic [COST_WIDTH-1:0] ik_t_reg;
    logic [NW-1:0]         ik_nh_reg;

    // edge load
    logic [IW-1:0]         ld_row_reg;
    logic [IW-1:0]         ld_col_reg;
    logic [COST_WIDTH-1:0] ld_d_reg;
    logic [COST_WIDTH-1:0] ld_t_reg;

    // route walk
    logic [COST_WIDTH-1:0] td_reg;
    logic [COST_WIDTH-1:0] tt_reg;
    logic [NW-1:0]         cur_reg;
    logic                  pend_reg;
    logic [NW-1:0]         pend_from_reg;
    logic [NW-1:0]         pend_to_reg;
    logic [CW-1:0]         cnt_reg;

    // result register
    logic                  out_valid_reg;
    logic                  out_reach_reg;
    logic [VERT_W-1:0]     out_from_reg;
    logic [VERT_W-1:0]     out_to_reg;
    logic [COST_WIDTH-1:0] out_dist_reg;
    logic [COST_WIDTH-1:0] out_time_reg;
    logic                  out_last_reg;

    // memory ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr_a;
    logic [AW-1:0] mem_raddr_b;
    logic [EW-1:0] mem_rdata_a;
    logic [EW-1:0] mem_rdata_b;

    // decoded fields and helpers
    logic [NW-1:0]         n_act;
    logic [IW-1:0]         nm1;
    logic [IW-1:0]         si;
    logic [IW-1:0]         ti;
    logic                  src_ok;
    logic                  tgt_ok;
    logic [IW-1:0]         clr_row;
    logic [IW-1:0]         clr_col;
    logic [COST_WIDTH-1:0] a_dist;
    logic [COST_WIDTH-1:0] a_time;
    logic [NW-1:0]         a_nh;
    logic [COST_WIDTH-1:0] sum_dist;
    logic [COST_WIDTH-1:0] sum_time;
    logic                  better;
    logic                  nh_ok;
    logic                  hop_done;
    logic                  edge_ok;
    logic                  accept;

    // vertex count of 0 acts as 1, above the capacity as the capacity
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_act = NW'(1);
        end
        else if (32'(vcount_reg) > MAX_VERTICES)
        begin
            n_act = NW'(MAX_VERTICES);
        end
        else
        begin
            n_act = NW'(vcount_reg);
        end
    end

    assign nm1     = IW'(n_act - NW'(1));
    assign si      = IW'(src_reg - VERT_W'(1));
    assign ti      = IW'(tgt_reg - VERT_W'(1));
    assign src_ok  = (src_reg != '0) && (32'(src_reg) <= 32'(n_act));
    assign tgt_ok  = (tgt_reg != '0) && (32'(tgt_reg) <= 32'(n_act));
    assign clr_row = clr_addr_reg[AW-1:IW];
    assign clr_col = clr_addr_reg[IW-1:0];
    assign edge_ok = (edge_from != '0) && (32'(edge_from) <= MAX_VERTICES) &&
                     (edge_to != '0) && (32'(edge_to) <= MAX_VERTICES);
    assign accept  = start && (state_reg == ST_IDLE);

    // entry layout: distance, time, next hop
    assign a_dist = mem_rdata_a[EW-1 -: COST_WIDTH];
    assign a_time = mem_rdata_a[NW +: COST_WIDTH];
    assign a_nh   = mem_rdata_a[NW-1:0];

    // next hop in the walk must lie within the active vertices
    assign nh_ok    = (a_nh != '0) && (32'(a_nh) <= 32'(n_act));
    assign hop_done = (32'(a_nh) == 32'(tgt_reg)) || ((32'(cnt_reg) + 1) == HOP_LIMIT);

    apsp_relax #(
        .COST_WIDTH (COST_WIDTH)
    ) u_relax (
        .metric   (metric_reg),
        .ik_dist  (ik_d_reg),
        .ik_time  (ik_t_reg),
        .kj_dist  (mem_rdata_b[EW-1 -: COST_WIDTH]),
        .kj_time  (mem_rdata_b[NW +: COST_WIDTH]),
        .ij_dist  (a_dist),
        .ij_time  (a_time),
        .sum_dist (sum_dist),
        .sum_time (sum_time),
        .better   (better)
    );

    // read addresses: port a follows the state, port b fetches row k during a row pass
    always_comb
    begin
        unique case (state_reg)
            ST_SETUP:     mem_raddr_a = {i_reg, k_reg};
            ST_LOAD_RD:   mem_raddr_a = {ld_row_reg, ld_col_reg};
            ST_REP_START: mem_raddr_a = {si, ti};
            ST_WALK_RD:   mem_raddr_a = {IW'(cur_reg - NW'(1)), ti};
            default:      mem_raddr_a = {i_reg, j_reg};
        endcase
    end

    assign mem_raddr_b = {k_reg, j_reg};

    // one write port: clearing pass, edge write-back, or a relaxation that improves
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {pi_reg, pj_reg};
        mem_wdata = {sum_dist, sum_time, ik_nh_reg};
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            if (clr_row == clr_col)
            begin
                mem_wdata = '0;
            end
            else
            begin
                mem_wdata = {INF, INF, NW'(clr_col) + NW'(1)};
            end
        end
        else if (state_reg == ST_LOAD_WR)
        begin
            mem_we    = 1'b1;
            mem_waddr = {ld_row_reg, ld_col_reg};
            mem_wdata = {ld_d_reg, ld_t_reg, a_nh};
        end
        else if (pv_reg && better)
        begin
            mem_we = 1'b1;
        end
    end

    apsp_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_matrix (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .rdata_a (mem_rdata_a),
        .raddr_b (mem_raddr_b),
        .rdata_b (mem_rdata_b)
    );

    // configuration registers, taken on every write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VCOUNT_RST;
            src_reg    <= VERTEX_RST;
            tgt_reg    <= VERTEX_RST;
            metric_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                CFG_VCOUNT: vcount_reg <= wr_data;
                CFG_SOURCE: src_reg    <= wr_data;
                CFG_TARGET: tgt_reg    <= wr_data;
                CFG_METRIC: metric_reg <= wr_data[0];
                default:    ;
            endcase
        end
    end

    // sequencer: state, counters, walk and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            pv_reg        <= 1'b0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= 1'b0;
            pv_reg        <= (state_reg == ST_ROW);
            pi_reg        <= i_reg;
            pj_reg        <= j_reg;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (&clr_addr_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (mode_t'(mode))
                            MODE_CLEAR:
                            begin
                                clr_addr_reg <= '0;
                                state_reg    <= ST_CLEAR;
                            end
                            MODE_EDGE:
                            begin
                                ld_row_reg <= IW'(edge_from - VERT_W'(1));
                                ld_col_reg <= IW'(edge_to - VERT_W'(1));
                                ld_d_reg   <= COST_WIDTH'(edge_distance);
                                ld_t_reg   <= COST_WIDTH'(edge_time);
                                if (edge_ok)
                                begin
                                    state_reg <= ST_LOAD_RD;
                                end
                            end
                            MODE_SOLVE:
                            begin
                                k_reg     <= '0;
                                i_reg     <= '0;
                                j_reg     <= '0;
                                state_reg <= ST_SETUP;
                            end
                            default: ;
                        endcase
                    end
                end

                ST_LOAD_RD: state_reg <= ST_LOAD_WR;

                ST_LOAD_WR: state_reg <= ST_IDLE;

                // fetch the row's entry through vertex k
                ST_SETUP: state_reg <= ST_LOADIK;

                ST_LOADIK:
                begin
                    ik_d_reg  <= a_dist;
                    ik_t_reg  <= a_time;
                    ik_nh_reg <= a_nh;
                    state_reg <= ST_ROW;
                end

                // one pair per cycle, the update is written in the cycle after
                ST_ROW:
                begin
                    j_reg <= j_reg + IW'(1);
                    if (j_reg == nm1)
                    begin
                        j_reg <= '0;
                        if (i_reg == nm1)
                        begin
                            i_reg <= '0;
                            if (k_reg == nm1)
                            begin
                                k_reg     <= '0;
                                state_reg <= ST_REP_START;
                            end
                            else
                            begin
                                k_reg     <= k_reg + IW'(1);
                                state_reg <= ST_SETUP;
                            end
                        end
                        else
                        begin
                            i_reg     <= i_reg + IW'(1);
                            state_reg <= ST_SETUP;
                        end
                    end
                end

                ST_REP_START:
                begin
                    if ((src_reg != '0) && (src_reg == tgt_reg))
                    begin
                        out_valid_reg <= 1'b1;
                        out_reach_reg <= 1'b1;
                        out_from_reg  <= src_reg;
                        out_to_reg    <= src_reg;
                        out_dist_reg  <= '0;
                        out_time_reg  <= '0;
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else if (!src_ok || !tgt_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reach_reg <= 1'b0;
                        out_from_reg  <= '0;
                        out_to_reg    <= '0;
                        out_dist_reg  <= INF;
                        out_time_reg  <= INF;
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_REP_COST;
                    end
                end

                ST_REP_COST:
                begin
                    td_reg   <= a_dist;
                    tt_reg   <= a_time;
                    cur_reg  <= NW'(src_reg);
                    pend_reg <= 1'b0;
                    cnt_reg  <= '0;
                    if ((metric_reg ? a_time : a_dist) == INF)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reach_reg <= 1'b0;
                        out_from_reg  <= '0;
                        out_to_reg    <= '0;
                        out_dist_reg  <= INF;
                        out_time_reg  <= INF;
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_WALK_RD;
                    end
                end

                ST_WALK_RD: state_reg <= ST_WALK_EV;

                // a hop is held back until the following lookup tells whether it ends the run
                ST_WALK_EV:
                begin
                    if (pend_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reach_reg <= 1'b1;
                        out_from_reg  <= VERT_W'(pend_from_reg);
                        out_to_reg    <= VERT_W'(pend_to_reg);
                        out_dist_reg  <= td_reg;
                        out_time_reg  <= tt_reg;
                        out_last_reg  <= !nh_ok;
                    end
                    else if (!nh_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reach_reg <= 1'b0;
                        out_from_reg  <= '0;
                        out_to_reg    <= '0;
                        out_dist_reg  <= INF;
                        out_time_reg  <= INF;
                        out_last_reg  <= 1'b1;
                    end

                    if (!nh_ok)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        pend_reg      <= 1'b1;
                        pend_from_reg <= cur_reg;
                        pend_to_reg   <= a_nh;
                        cur_reg       <= a_nh;
                        cnt_reg       <= cnt_reg + CW'(1);
                        state_reg     <= hop_done ? ST_EMIT_LAST : ST_WALK_RD;
                    end
                end

                ST_EMIT_LAST:
                begin
                    out_valid_reg <= 1'b1;
                    out_reach_reg <= 1'b1;
                    out_from_reg  <= VERT_W'(pend_from_reg);
                    out_to_reg    <= VERT_W'(pend_to_reg);
                    out_dist_reg  <= td_reg;
                    out_time_reg  <= tt_reg;
                    out_last_reg  <= 1'b1;
                    pend_reg      <= 1'b0;
                    state_reg     <= ST_IDLE;
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign result_valid   = out_valid_reg;
    assign reachable      = out_reach_reg;
    assign hop_from       = out_from_reg;
    assign hop_to         = out_to_reg;
    assign total_distance = out_dist_reg;
    assign total_time     = out_time_reg;
    assign last           = out_last_reg;

    // every result transfer comes out of a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
    else $error("result without a preceding busy cycle");

    // a pending relaxation write only trails a row pass
    assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> (state_reg == ST_ROW || state_reg == ST_SETUP ||
                    state_reg == ST_REP_START))
    else $error("relaxation write outside a solve");

    // the walk never counts past the hop limit
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= HOP_LIMIT)
    else $error("hop count past limit");

    // the last flag of a route closes it: the cycle after, no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid)
    else $error("result after the closing transfer");

endmodule
